// ===== hw/rtl/tcru_pkg.sv =====
// Shared types and codes for the typed column record unpacker.
`timescale 1ns / 1ps

package tcru_pkg;

    // Input beat: one record byte and its end mark
    typedef struct packed {
        logic [7:0] record_byte;
        logic       end_of_record;
    } in_beat_t;

    // Result beat
    typedef struct packed {
        logic [1:0]         event_kind;
        logic [7:0]         column_number;
        logic [2:0]         column_kind;
        logic signed [63:0] field_value;
        logic [7:0]         payload_data;
        logic               column_done;
        logic               record_done;
        logic [1:0]         record_status;
    } out_beat_t;

    // Event kinds
    localparam logic [1:0] EV_COUNT   = 2'd0;
    localparam logic [1:0] EV_VALUE   = 2'd1;
    localparam logic [1:0] EV_PAYLOAD = 2'd2;
    localparam logic [1:0] EV_END     = 2'd3;

    // Column kinds
    localparam logic [2:0] KIND_INT   = 3'd0;
    localparam logic [2:0] KIND_FLOAT = 3'd1;
    localparam logic [2:0] KIND_TEXT  = 3'd2;
    localparam logic [2:0] KIND_BLOB  = 3'd3;
    localparam logic [2:0] KIND_NULL  = 3'd4;

    // Header type codes
    localparam logic [2:0] TYPE_INT   = 3'd1;
    localparam logic [2:0] TYPE_FLOAT = 3'd2;
    localparam logic [2:0] TYPE_TEXT  = 3'd3;
    localparam logic [2:0] TYPE_BLOB  = 3'd4;
    localparam logic [2:0] TYPE_NULL  = 3'd5;

    // Record status
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TRUNCATED = 2'd1;
    localparam logic [1:0] ST_BAD_TYPE  = 2'd2;
    localparam logic [1:0] ST_NEG_LEN   = 2'd3;

    // A float field always carries eight raw bytes
    localparam logic [4:0] FLOAT_BYTES = 5'd8;

endpackage

// ===== hw/rtl/typed_column_record_unpacker_core.sv =====
// Typed column record unpacker: byte-wide record parser with registered in and out.
`timescale 1ns / 1ps

// Takes one record byte per beat and gives at most one result beat per input
// beat, in order. One byte is accepted every cycle when the output side keeps
// up; each byte passes an input register, the parse logic (a byte shift into
// the 64-bit field value, a count step and a compare) and the result register.
// The result register and the input register together let a new byte be
// taken while a finished result still waits. Bytes that produce no result
// (field bytes before the last, bytes after the last column or after an
// error) simply drop out. The final byte of a record always yields a beat
// with record_done set and record_status valid; a nonzero status means the
// record's results are to be discarded. There is no clearing pass after reset.
module typed_column_record_unpacker_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  tcru_pkg::in_beat_t   in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output tcru_pkg::out_beat_t  out_data
);
    import tcru_pkg::*;

    localparam logic [2:0] PH_COUNT       = 3'd0;
    localparam logic [2:0] PH_HEADER      = 3'd1;
    localparam logic [2:0] PH_FIELD_FIRST = 3'd2;
    localparam logic [2:0] PH_FIELD_REST  = 3'd3;
    localparam logic [2:0] PH_PAYLOAD     = 3'd4;
    localparam logic [2:0] PH_DONE        = 3'd5;

    // input register
    logic      in_valid_reg;
    in_beat_t  in_beat_reg;

    // parse state
    logic [2:0]  phase_reg,       phase_next;
    logic [7:0]  cols_total_reg,  cols_total_next;
    logic [7:0]  col_pos_reg,     col_pos_next;
    logic [2:0]  cur_kind_reg,    cur_kind_next;
    logic [4:0]  field_left_reg,  field_left_next;
    logic [63:0] acc_reg,         acc_next;
    logic [30:0] pay_left_reg,    pay_left_next;
    logic [1:0]  err_reg,         err_next;

    // result register
    logic      out_valid_reg;
    out_beat_t out_beat_reg,  res_beat;
    logic      emit;

    logic proc_go;

    assign proc_go   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !proc_go;
    assign out_valid = out_valid_reg;
    assign out_data  = out_beat_reg;

    always_comb
    begin
        logic [7:0]  b;
        logic [2:0]  t;
        logic [4:0]  n;
        logic        last_col;
        logic [63:0] acc_new;
        logic [4:0]  left_dec;
        logic [31:0] len;
        logic [30:0] pay_dec;
        logic        finish;

        b        = in_beat_reg.record_byte;
        t        = b[2:0];
        n        = b[7:3];
        last_col = ({1'b0, col_pos_reg} + 9'd1) >= {1'b0, cols_total_reg};
        acc_new  = (phase_reg == PH_FIELD_FIRST) ? {{56{b[7]}}, b} : {acc_reg[55:0], b};
        left_dec = field_left_reg - 5'd1;
        len      = acc_new[31:0];
        pay_dec  = pay_left_reg - 31'd1;
        finish   = 1'b0;

        phase_next      = phase_reg;
        cols_total_next = cols_total_reg;
        col_pos_next    = col_pos_reg;
        cur_kind_next   = cur_kind_reg;
        field_left_next = field_left_reg;
        acc_next        = acc_reg;
        pay_left_next   = pay_left_reg;
        err_next        = err_reg;

        emit     = 1'b0;
        res_beat = '0;

        unique case (phase_reg)
            PH_COUNT:
            begin
                cols_total_next        = b;
                col_pos_next           = 8'd0;
                emit                   = 1'b1;
                res_beat.event_kind    = EV_COUNT;
                res_beat.field_value   = {56'd0, b};
                phase_next             = (b != 8'd0) ? PH_HEADER : PH_DONE;
            end
            PH_HEADER:
            begin
                acc_next = '0;
                unique case (t)
                    TYPE_INT:   cur_kind_next = KIND_INT;
                    TYPE_FLOAT: cur_kind_next = KIND_FLOAT;
                    TYPE_TEXT:  cur_kind_next = KIND_TEXT;
                    TYPE_BLOB:  cur_kind_next = KIND_BLOB;
                    TYPE_NULL:  cur_kind_next = KIND_NULL;
                    default:    cur_kind_next = cur_kind_reg;
                endcase
                if (t == TYPE_INT || t == TYPE_FLOAT || t == TYPE_TEXT
                    || t == TYPE_BLOB || t == TYPE_NULL)
                begin
                    if (t == TYPE_FLOAT)
                    begin
                        n = FLOAT_BYTES;
                    end
                    if (t == TYPE_NULL || n == 5'd0)
                    begin
                        emit                   = 1'b1;
                        res_beat.event_kind    = EV_VALUE;
                        res_beat.column_number = col_pos_reg;
                        res_beat.column_kind   = cur_kind_next;
                        res_beat.column_done   = 1'b1;
                        finish                 = 1'b1;
                    end
                    else
                    begin
                        field_left_next = n;
                        phase_next      = PH_FIELD_FIRST;
                    end
                end
                else
                begin
                    err_next   = ST_BAD_TYPE;
                    phase_next = PH_DONE;
                end
            end
            PH_FIELD_FIRST, PH_FIELD_REST:
            begin
                acc_next        = acc_new;
                phase_next      = PH_FIELD_REST;
                field_left_next = left_dec;
                if (left_dec == 5'd0)
                begin
                    if (cur_kind_reg == KIND_INT || cur_kind_reg == KIND_FLOAT)
                    begin
                        emit                   = 1'b1;
                        res_beat.event_kind    = EV_VALUE;
                        res_beat.column_number = col_pos_reg;
                        res_beat.column_kind   = cur_kind_reg;
                        res_beat.field_value   = acc_new;
                        res_beat.column_done   = 1'b1;
                        finish                 = 1'b1;
                    end
                    else if (len[31])
                    begin
                        err_next   = ST_NEG_LEN;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        emit                   = 1'b1;
                        res_beat.event_kind    = EV_VALUE;
                        res_beat.column_number = col_pos_reg;
                        res_beat.column_kind   = cur_kind_reg;
                        res_beat.field_value   = {32'd0, len};
                        if (len == 32'd0)
                        begin
                            res_beat.column_done = 1'b1;
                            finish               = 1'b1;
                        end
                        else
                        begin
                            pay_left_next = len[30:0];
                            phase_next    = PH_PAYLOAD;
                        end
                    end
                end
            end
            PH_PAYLOAD:
            begin
                emit                   = 1'b1;
                res_beat.event_kind    = EV_PAYLOAD;
                res_beat.column_number = col_pos_reg;
                res_beat.column_kind   = cur_kind_reg;
                res_beat.payload_data  = b;
                pay_left_next          = pay_dec;
                if (pay_dec == 31'd0)
                begin
                    res_beat.column_done = 1'b1;
                    finish               = 1'b1;
                end
            end
            default:
            begin
                // done or unused code: byte ignored
            end
        endcase

        if (finish)
        begin
            if (last_col)
            begin
                phase_next = PH_DONE;
            end
            else
            begin
                col_pos_next = col_pos_reg + 8'd1;
                phase_next   = PH_HEADER;
            end
        end

        if (in_beat_reg.end_of_record)
        begin
            if (err_next == ST_OK && phase_next != PH_DONE)
            begin
                err_next = ST_TRUNCATED;
            end
            if (!emit)
            begin
                emit                = 1'b1;
                res_beat            = '0;
                res_beat.event_kind = EV_END;
            end
            res_beat.record_done   = 1'b1;
            res_beat.record_status = err_next;
            // back to the start for the next record
            phase_next      = PH_COUNT;
            cols_total_next = '0;
            col_pos_next    = '0;
            cur_kind_next   = '0;
            field_left_next = '0;
            acc_next        = '0;
            pay_left_next   = '0;
            err_next        = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            phase_reg      <= PH_COUNT;
            cols_total_reg <= '0;
            col_pos_reg    <= '0;
            cur_kind_reg   <= '0;
            field_left_reg <= '0;
            acc_reg        <= '0;
            pay_left_reg   <= '0;
            err_reg        <= ST_OK;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (proc_go)
            begin
                in_valid_reg <= 1'b0;
            end

            if (proc_go)
            begin
                out_valid_reg  <= emit;
                phase_reg      <= phase_next;
                cols_total_reg <= cols_total_next;
                col_pos_reg    <= col_pos_next;
                cur_kind_reg   <= cur_kind_next;
                field_left_reg <= field_left_next;
                acc_reg        <= acc_next;
                pay_left_reg   <= pay_left_next;
                err_reg        <= err_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_beat_reg <= in_data;
        end
        if (proc_go && emit)
        begin
            out_beat_reg <= res_beat;
        end
    end

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the typed column record unpacker core.
`timescale 1ns / 1ps

module tb;
    import tcru_pkg::*;

    // Header type codes the block must reject
    localparam logic [2:0] TYPE_RSVD0 = 3'd0;
    localparam logic [2:0] TYPE_RSVD6 = 3'd6;
    localparam logic [2:0] TYPE_RSVD7 = 3'd7;

    localparam int RANDOM_BYTES = 650;

    typedef enum logic [2:0] {
        AWAIT_COUNT,
        AWAIT_HEADER,
        FIELD_LEAD,
        FIELD_TAIL,
        IN_PAYLOAD,
        SKIP_REST
    } parse_state_t;

    // hold set: no data, the sender waits until all results are back
    typedef struct packed {
        in_beat_t beat;
        logic     hold;
    } pending_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    in_beat_t  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_beat_t out_data;

    pending_t  pending_beats[$];
    out_beat_t expected_events[$];
    logic [7:0] record_bytes[$];

    // parser image
    parse_state_t parse_state = AWAIT_COUNT;
    logic [7:0]   col_total = '0;
    logic [7:0]   col_index = '0;
    logic [2:0]   col_kind = KIND_INT;
    logic [4:0]   field_left = '0;
    logic [63:0]  field_acc = '0;
    logic [30:0]  payload_left = '0;
    logic [1:0]   record_err = ST_OK;

    int mismatches = 0;
    int results_seen = 0;
    int records_seen = 0;
    int records_failed = 0;
    int bytes_fed = 0;

    int       idle_left = 0;
    int       drv_calm = 0;
    int       stall_left = 0;
    int       mon_calm = 0;
    logic     send_now;
    pending_t next_item;

    always #5 clk = ~clk;

    typed_column_record_unpacker_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        else if (r < 95)
            return $urandom_range(3, 8);
        else
            return $urandom_range(20, 60);
    endfunction

    function void close_column();
        if ({1'b0, col_index} + 9'd1 >= {1'b0, col_total})
            parse_state = SKIP_REST;
        else
        begin
            col_index = col_index + 8'd1;
            parse_state = AWAIT_HEADER;
        end
    endfunction

    // Advance the parser image by one byte and queue the result it yields
    task automatic take_record_byte(input in_beat_t beat);
        out_beat_t  res;
        logic       emit;
        logic       known;
        logic [7:0] b;
        logic [4:0] nbytes;
        res = '0;
        emit = 1'b0;
        known = 1'b1;
        b = beat.record_byte;
        case (parse_state)
            AWAIT_COUNT:
            begin
                col_total = b;
                col_index = '0;
                emit = 1'b1;
                res.event_kind = EV_COUNT;
                res.field_value = {56'd0, b};
                parse_state = (b != 8'd0) ? AWAIT_HEADER : SKIP_REST;
            end
            AWAIT_HEADER:
            begin
                nbytes = b[7:3];
                field_acc = '0;
                case (b[2:0])
                    TYPE_INT:   col_kind = KIND_INT;
                    TYPE_FLOAT: col_kind = KIND_FLOAT;
                    TYPE_TEXT:  col_kind = KIND_TEXT;
                    TYPE_BLOB:  col_kind = KIND_BLOB;
                    TYPE_NULL:  col_kind = KIND_NULL;
                    default:    known = 1'b0;
                endcase
                if (!known)
                begin
                    record_err = ST_BAD_TYPE;
                    parse_state = SKIP_REST;
                end
                else
                begin
                    if (col_kind == KIND_FLOAT)
                        nbytes = FLOAT_BYTES;
                    if (col_kind == KIND_NULL || nbytes == 5'd0)
                    begin
                        emit = 1'b1;
                        res.event_kind = EV_VALUE;
                        res.column_number = col_index;
                        res.column_kind = col_kind;
                        res.column_done = 1'b1;
                        close_column();
                    end
                    else
                    begin
                        field_left = nbytes;
                        parse_state = FIELD_LEAD;
                    end
                end
            end
            FIELD_LEAD, FIELD_TAIL:
            begin
                // first byte is sign-extended, later ones shift in below it
                if (parse_state == FIELD_LEAD)
                    field_acc = {{56{b[7]}}, b};
                else
                    field_acc = {field_acc[55:0], b};
                parse_state = FIELD_TAIL;
                field_left = field_left - 5'd1;
                if (field_left == 5'd0)
                begin
                    if (col_kind == KIND_INT || col_kind == KIND_FLOAT)
                    begin
                        emit = 1'b1;
                        res.event_kind = EV_VALUE;
                        res.column_number = col_index;
                        res.column_kind = col_kind;
                        res.field_value = field_acc;
                        res.column_done = 1'b1;
                        close_column();
                    end
                    else if (field_acc[31])
                    begin
                        record_err = ST_NEG_LEN;
                        parse_state = SKIP_REST;
                    end
                    else
                    begin
                        emit = 1'b1;
                        res.event_kind = EV_VALUE;
                        res.column_number = col_index;
                        res.column_kind = col_kind;
                        res.field_value = {32'd0, field_acc[31:0]};
                        if (field_acc[31:0] == 32'd0)
                        begin
                            res.column_done = 1'b1;
                            close_column();
                        end
                        else
                        begin
                            payload_left = field_acc[30:0];
                            parse_state = IN_PAYLOAD;
                        end
                    end
                end
            end
            IN_PAYLOAD:
            begin
                emit = 1'b1;
                res.event_kind = EV_PAYLOAD;
                res.column_number = col_index;
                res.column_kind = col_kind;
                res.payload_data = b;
                payload_left = payload_left - 31'd1;
                if (payload_left == 31'd0)
                begin
                    res.column_done = 1'b1;
                    close_column();
                end
            end
            default:
            begin
            end
        endcase

        if (beat.end_of_record)
        begin
            if (record_err == ST_OK && parse_state != SKIP_REST)
                record_err = ST_TRUNCATED;
            if (!emit)
            begin
                res = '0;
                res.event_kind = EV_END;
                emit = 1'b1;
            end
            res.record_done = 1'b1;
            res.record_status = record_err;
            records_seen++;
            if (record_err != ST_OK)
                records_failed++;
            parse_state = AWAIT_COUNT;
            col_total = '0;
            col_index = '0;
            col_kind = KIND_INT;
            field_left = '0;
            field_acc = '0;
            payload_left = '0;
            record_err = ST_OK;
        end

        if (emit)
            expected_events.push_back(res);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch on result beat %0d: %s got %0h expected %0h",
                     results_seen, what, got, want);
    endtask

    task automatic check_result(input out_beat_t got);
        out_beat_t want;
        results_seen++;
        if (expected_events.size() == 0)
            report_mismatch("unexpected beat, event_kind", got.event_kind, 0);
        else
        begin
            want = expected_events.pop_front();
            if (got.event_kind !== want.event_kind)
                report_mismatch("event_kind", got.event_kind, want.event_kind);
            if (got.column_number !== want.column_number)
                report_mismatch("column_number", got.column_number, want.column_number);
            if (got.column_kind !== want.column_kind)
                report_mismatch("column_kind", got.column_kind, want.column_kind);
            if (got.field_value !== want.field_value)
                report_mismatch("field_value", got.field_value, want.field_value);
            if (got.payload_data !== want.payload_data)
                report_mismatch("payload_data", got.payload_data, want.payload_data);
            if (got.column_done !== want.column_done)
                report_mismatch("column_done", got.column_done, want.column_done);
            if (got.record_done !== want.record_done)
                report_mismatch("record_done", got.record_done, want.record_done);
            if (got.record_status !== want.record_status)
                report_mismatch("record_status", got.record_status, want.record_status);
        end
    endtask

    // Turn the bytes gathered so far into beats, end mark on the last one
    task automatic flush_record();
        pending_t p;
        for (int i = 0; i < record_bytes.size(); i++)
        begin
            p.beat.record_byte = record_bytes[i];
            p.beat.end_of_record = (i == record_bytes.size() - 1);
            p.hold = 1'b0;
            pending_beats.push_back(p);
        end
        record_bytes.delete();
    endtask

    task automatic pause_for_drain();
        pending_t p;
        p = '0;
        p.hold = 1'b1;
        pending_beats.push_back(p);
    endtask

    // Sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                take_record_byte(in_data);
                bytes_fed++;
            end
            if (!(in_valid && in_stall))
            begin
                send_now = 1'b0;
                if (in_valid)
                begin
                    if (drv_calm != 0)
                        drv_calm--;
                    else if ($urandom_range(0, 39) == 0)
                        drv_calm = $urandom_range(30, 80);
                    else if ($urandom_range(0, 2) == 0)
                        idle_left = pick_pause();
                end
                if (idle_left != 0)
                    idle_left--;
                else if (pending_beats.size() != 0)
                begin
                    if (pending_beats[0].hold)
                    begin
                        if (expected_events.size() == 0)
                            void'(pending_beats.pop_front());
                    end
                    else
                    begin
                        next_item = pending_beats.pop_front();
                        send_now = 1'b1;
                    end
                end
                in_valid <= send_now;
                if (send_now)
                    in_data <= next_item.beat;
            end
        end
    end

    // Receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
                check_result(out_data);
            if (stall_left == 0)
            begin
                if (mon_calm != 0)
                    mon_calm--;
                else if ($urandom_range(0, 99) == 0)
                    mon_calm = $urandom_range(30, 100);
                else if ($urandom_range(0, 3) == 0)
                    stall_left = pick_pause();
            end
            out_stall <= (stall_left != 0);
            if (stall_left != 0)
                stall_left--;
        end
    end

    initial
    begin
        int         random_bytes;
        int         r;
        int         flaw;
        int         ncols;
        int         flaw_col;
        int         n;
        int         plen;
        int         cut;
        logic [2:0] code;
        logic       mid_drain_done;

        // zero columns, then a trailing byte that closes the record
        record_bytes = '{8'd0, 8'h5A};
        flush_record();
        // empty integer, null with count bits, one-byte text, empty blob
        record_bytes = '{8'd4, {5'd0, TYPE_INT}, {5'd31, TYPE_NULL}, {5'd1, TYPE_TEXT},
                         8'd1, 8'h41, {5'd1, TYPE_BLOB}, 8'd0};
        flush_record();
        // float ignores its count bits; record cut inside the next integer
        record_bytes = '{8'd2, {5'd10, TYPE_FLOAT}, 8'h80, 8'h00, 8'h00, 8'h00,
                         8'h00, 8'h00, 8'h00, 8'h01, {5'd2, TYPE_INT}, 8'hFF};
        flush_record();
        // unknown type, rest of record skipped
        record_bytes = '{8'd3, {5'd31, TYPE_RSVD7}, 8'h33};
        flush_record();
        // negative text length on the final byte: end status only
        record_bytes = '{8'd1, {5'd1, TYPE_TEXT}, 8'h80};
        flush_record();
        pause_for_drain();

        random_bytes = 0;
        mid_drain_done = 1'b0;
        while (random_bytes < RANDOM_BYTES)
        begin
            r = $urandom_range(0, 99);
            if (r < 5)
            begin
                repeat ($urandom_range(1, 10))
                    record_bytes.push_back(8'($urandom));
            end
            else
            begin
                r = $urandom_range(0, 99);
                flaw = (r < 70) ? 0 : (r < 80) ? 1 : (r < 87) ? 2 : (r < 94) ? 3 : 4;
                r = $urandom_range(0, 99);
                ncols = (r < 8) ? 0 : (r < 95) ? $urandom_range(1, 4) : $urandom_range(5, 12);
                flaw_col = (ncols == 0) ? -1 : $urandom_range(0, ncols - 1);
                record_bytes.push_back(8'(ncols));
                for (int c = 0; c < ncols; c++)
                begin
                    if (flaw >= 2 && c == flaw_col)
                    begin
                        case (flaw)
                            2:
                            begin
                                case ($urandom_range(0, 2))
                                    0:       code = TYPE_RSVD0;
                                    1:       code = TYPE_RSVD6;
                                    default: code = TYPE_RSVD7;
                                endcase
                                record_bytes.push_back({5'($urandom), code});
                            end
                            3:
                            begin
                                // top bit of the length set after sign extension
                                n = $urandom_range(1, 4);
                                code = $urandom_range(0, 1) ? TYPE_TEXT : TYPE_BLOB;
                                record_bytes.push_back({5'(n), code});
                                record_bytes.push_back(8'($urandom) | 8'h80);
                                repeat (n - 1)
                                    record_bytes.push_back(8'($urandom));
                            end
                            default:
                            begin
                                // huge length: record always ends inside the payload
                                record_bytes.push_back({5'd4, TYPE_BLOB});
                                record_bytes.push_back(8'h7F);
                                record_bytes.push_back(8'hFF);
                                record_bytes.push_back(8'($urandom));
                                record_bytes.push_back(8'($urandom));
                                repeat ($urandom_range(0, 5))
                                    record_bytes.push_back(8'($urandom));
                            end
                        endcase
                    end
                    else
                    begin
                        code = 3'($urandom_range(TYPE_INT, TYPE_NULL));
                        case (code)
                            TYPE_INT:
                            begin
                                r = $urandom_range(0, 99);
                                n = (r < 10) ? 0 : (r < 90) ? $urandom_range(1, 8)
                                                            : $urandom_range(9, 31);
                                record_bytes.push_back({5'(n), TYPE_INT});
                                repeat (n)
                                    record_bytes.push_back(8'($urandom));
                            end
                            TYPE_FLOAT:
                            begin
                                record_bytes.push_back({5'($urandom), TYPE_FLOAT});
                                repeat (8)
                                    record_bytes.push_back(8'($urandom));
                            end
                            TYPE_NULL:
                                record_bytes.push_back({5'($urandom), TYPE_NULL});
                            default:
                            begin
                                plen = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                                   : $urandom_range(0, 6);
                                n = (plen == 0 && $urandom_range(0, 1)) ? 0
                                                                        : $urandom_range(1, 4);
                                // wider fields: bytes above the low 32 bits are don't-care
                                if ($urandom_range(0, 9) == 0)
                                    n = $urandom_range(5, 10);
                                record_bytes.push_back({5'(n), code});
                                for (int k = n - 1; k >= 0; k--)
                                    record_bytes.push_back((k < 4) ? 8'(plen >> (8 * k))
                                                                   : 8'($urandom));
                                repeat (plen)
                                    record_bytes.push_back(8'($urandom));
                            end
                        endcase
                    end
                end
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 3))
                        record_bytes.push_back(8'($urandom));
                if (flaw == 1 && record_bytes.size() > 1)
                begin
                    cut = $urandom_range(1, record_bytes.size() - 1);
                    while (record_bytes.size() > cut)
                        void'(record_bytes.pop_back());
                end
            end
            random_bytes += record_bytes.size();
            flush_record();
            if (!mid_drain_done && random_bytes >= RANDOM_BYTES / 2)
            begin
                pause_for_drain();
                mid_drain_done = 1'b1;
            end
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_beats.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("covered %0d records (%0d flagged bad) from %0d input beats",
                 records_seen, records_failed, bytes_fed);
        $display("checked %0d result beats, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("timeout with %0d results still expected", expected_events.size());
        $display("FAIL");
        $finish;
    end

endmodule
